>>> design/svm_pkg.sv
`default_nettype none
package svm_pkg;
    localparam int MemWordsDef  = 16384;
    localparam int TextWordsDef = 65536;

    typedef enum logic [5:0] {
        OP_LLA = 6'd0, OP_IMM = 6'd1, OP_JMP = 6'd2, OP_JSR = 6'd3,
        OP_BZ = 6'd4, OP_BNZ = 6'd5, OP_ENT = 6'd6, OP_ADJ = 6'd7,
        OP_LEV = 6'd8, OP_LI = 6'd9, OP_LC = 6'd10, OP_SI = 6'd11,
        OP_SC = 6'd12, OP_PSH = 6'd13, OP_OR = 6'd14, OP_XOR = 6'd15,
        OP_AND = 6'd16, OP_EQ = 6'd17, OP_NE = 6'd18, OP_LT = 6'd19,
        OP_GT = 6'd20, OP_LE = 6'd21, OP_GE = 6'd22, OP_SHL = 6'd23,
        OP_SHR = 6'd24, OP_ADD = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27,
        OP_DIV = 6'd28, OP_MOD = 6'd29, OP_EXIT = 6'd56, OP_LOAD = 6'd57,
        OP_START = 6'd58
    } t_op;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_EXIT = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] CFG_ENTRY = 2'd0;
    localparam logic [1:0] CFG_RET   = 2'd1;
    localparam logic [1:0] CFG_ARGC  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_RD, S_RDW, S_EXEC, S_MUL, S_DIV,
        S_DIVFIX, S_BYTEW, S_LEV2, S_START, S_OUT
    } t_state;

    typedef struct packed {
        logic [5:0]  command;
        logic [63:0] operand;
        logic [13:0] load_address;
    } t_in;

    typedef struct packed {
        logic [15:0] fetch_pc;
        logic [63:0] accumulator;
        logic [1:0]  status;
        logic [63:0] exit_code;
    } t_out;
endpackage
`default_nettype wire

>>> design/stack_vm_instruction_core_top.sv
// Sequencing: preload and halted beats skip execution; LI, LC and popping opcodes read
// memory first (LEV and SC a second word); START writes three stack words; MUL forms three
// 32x32 partial products through one multiplier; DIV/MOD produce one quotient bit a cycle.
// Throughput: one instruction at a time; ready is low while an instruction runs.
// Reset: synchronous active low; afterwards a clearing pass writes zero to every
// memory word, one per cycle, before the first instruction.
`default_nettype none
module stack_vm_instruction_core_top #(
    parameter int MEM_WORDS  = svm_pkg::MemWordsDef,
    parameter int TEXT_WORDS = svm_pkg::TextWordsDef
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire svm_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output svm_pkg::t_out     o_data,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
    import svm_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int BW = AW + 3;
    localparam int TW = $clog2(TEXT_WORDS);

    logic [63:0] mem [MEM_WORDS];
    logic [63:0] r_rdata;
    logic        r_we;
    logic [AW-1:0] r_waddr, r_raddr;
    logic [63:0] r_wdata;

    t_state r_state, n_state;
    logic [15:0] r_entry, r_ret;
    logic [7:0]  r_argc;
    logic [63:0] r_acc, r_opd, r_tos, r_exit;
    logic [AW-1:0] r_sp, r_fp;
    logic [TW-1:0] r_pc, r_next;
    logic [1:0]  r_halt;
    logic [5:0]  r_cmd;
    logic [13:0] r_la;
    logic [AW-1:0] r_clr;
    logic [6:0]  r_cnt;
    logic [1:0]  r_mstep;
    logic [63:0] r_quo, r_rem, r_dvd, r_dvs;
    logic [63:0] r_mlo;
    logic        r_xn, r_yn;
    logic [2:0]  r_bsel;
    // divisor zero: r_dvd was shifted out; keep original for MOD
    logic [63:0] r_dvd0;

    // memory: one write, one read port, registered read
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_waddr] <= r_wdata;
        r_rdata <= mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0; r_ret <= '0; r_argc <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY: r_entry <= i_cfg_data;
                CFG_RET:   r_ret   <= i_cfg_data;
                CFG_ARGC:  r_argc  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    // state is frozen while the result beat waits
    assign o_data  = {16'(r_pc), r_acc, r_halt, r_exit};

    // modular reductions of the operand
    function automatic logic [AW-1:0] wmod(input logic [63:0] v);
        wmod = v[AW-1:0];
    endfunction
    function automatic logic [TW-1:0] tmod(input logic [63:0] v);
        tmod = v[TW-1:0];
    endfunction

    logic [TW-1:0] pc_step;
    logic          cmp_lt_pa, cmp_lt_ap;
    logic [BW-1:0] tos_b, acc_b;
    logic [63:0] shl_v, shr_v;
    logic [64:0] dsub;
    logic [63:0] mprod;
    logic [31:0] ma, mb;
    logic [63:0] sc_word;

    assign pc_step = r_pc + ((r_cmd <= 6'd7) ? TW'(2) : TW'(1));
    assign cmp_lt_pa = $signed(r_tos) < $signed(r_acc);
    assign cmp_lt_ap = $signed(r_acc) < $signed(r_tos);
    assign tos_b = r_tos[BW-1:0];
    assign acc_b = r_acc[BW-1:0];
    assign shl_v = (r_acc[63:6] != 0) ? 64'd0 : (r_tos << r_acc[5:0]);
    assign shr_v = (r_acc[63:6] != 0) ? {64{r_tos[63]}}
                                      : 64'($signed(r_tos) >>> r_acc[5:0]);
    assign dsub = {r_rem[62:0], r_dvd[63]} - {1'b0, r_dvs};
    always_comb begin
        case (r_mstep)
            2'd0: begin ma = r_tos[31:0];  mb = r_acc[31:0];  end
            2'd1: begin ma = r_tos[63:32]; mb = r_acc[31:0];  end
            default: begin ma = r_tos[31:0]; mb = r_acc[63:32]; end
        endcase
    end
    assign mprod = ma * mb;

    // target word with the stored byte merged in
    always_comb begin
        sc_word = r_rdata;
        sc_word[r_bsel*8 +: 8] = r_acc[7:0];
    end

    logic needs_pop;
    always_comb begin
        needs_pop = 1'b0;
        case (r_cmd)
            OP_LEV, OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT,
            OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL,
            OP_DIV, OP_MOD, OP_EXIT: needs_pop = 1'b1;
            default: needs_pop = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(MEM_WORDS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_DEC;
            S_DEC: begin
                if (r_cmd == OP_LOAD) n_state = S_OUT;
                else if (r_cmd == OP_START) n_state = S_START;
                else if (r_halt != ST_RUN) n_state = S_OUT;
                else if (needs_pop || r_cmd == OP_LI || r_cmd == OP_LC)
                    n_state = S_RD;
                else n_state = S_EXEC;
            end
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = (r_cmd == OP_LEV) ? S_LEV2
                             : (r_cmd == OP_SC) ? S_BYTEW : S_EXEC;
            S_LEV2:  n_state = S_EXEC;
            S_BYTEW: n_state = S_EXEC;
            S_EXEC: begin
                if (r_cmd == OP_MUL) n_state = S_MUL;
                else if (r_cmd == OP_DIV || r_cmd == OP_MOD) n_state = S_DIV;
                else n_state = S_OUT;
            end
            S_MUL:    if (r_mstep == 2'd3) n_state = S_OUT;
            S_DIV:    if (r_cnt == 7'd64) n_state = S_DIVFIX;
            S_DIVFIX: n_state = S_OUT;
            S_START:  if (r_mstep == 2'd2) n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        if (!i_rst_n) begin
            r_acc <= '0; r_sp <= '0; r_fp <= '0; r_pc <= '0; r_halt <= ST_RUN;
            r_clr <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_we <= 1'b1; r_waddr <= r_clr; r_wdata <= '0;
                    r_clr <= r_clr + AW'(1);
                end
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_data.command; r_opd <= i_data.operand;
                    r_la <= i_data.load_address; r_exit <= '0; r_mstep <= '0;
                end
                S_DEC: begin
                    if (r_cmd == OP_LOAD) begin
                        r_we <= 1'b1; r_waddr <= AW'(r_la); r_wdata <= r_opd;
                    end
                    r_next <= pc_step;
                    // LI/LC read at the accumulator address, LEV at the frame pointer, else pop
                    r_raddr <= (r_cmd == OP_LI || r_cmd == OP_LC) ? acc_b[BW-1:3]
                             : (r_cmd == OP_LEV) ? r_fp : r_sp;
                    r_bsel <= acc_b[2:0];
                end
                S_RD: ;
                S_RDW: begin
                    r_tos <= r_rdata;
                    if (r_cmd == OP_LEV) begin
                        r_fp <= wmod(r_rdata); r_raddr <= r_fp + AW'(1);
                        r_sp <= r_fp + AW'(2);
                    end else if (needs_pop && r_cmd != OP_EXIT) begin
                        r_sp <= r_sp + AW'(1);
                        if (r_cmd == OP_SC) begin
                            r_raddr <= r_rdata[BW-1:3]; r_bsel <= r_rdata[2:0];
                        end
                    end
                end
                S_LEV2: ;
                S_BYTEW: ;
                S_EXEC: begin
                    r_pc <= r_next;
                    case (r_cmd)
                        OP_LLA: r_acc <= 64'({r_fp + wmod(r_opd), 3'b000});
                        OP_IMM: r_acc <= r_opd;
                        OP_JMP: r_pc <= tmod(r_opd);
                        OP_JSR: begin
                            r_we <= 1'b1; r_waddr <= r_sp - AW'(1);
                            r_wdata <= 64'(r_next); r_sp <= r_sp - AW'(1);
                            r_pc <= tmod(r_opd);
                        end
                        OP_BZ:  if (r_acc == 0) r_pc <= tmod(r_opd);
                        OP_BNZ: if (r_acc != 0) r_pc <= tmod(r_opd);
                        OP_ENT: begin
                            r_we <= 1'b1; r_waddr <= r_sp - AW'(1);
                            r_wdata <= 64'(r_fp); r_fp <= r_sp - AW'(1);
                            r_sp <= r_sp - AW'(1) - wmod(r_opd);
                        end
                        OP_ADJ: r_sp <= r_sp + wmod(r_opd);
                        OP_LEV: r_pc <= tmod(r_rdata);
                        OP_LI:  r_acc <= r_tos;
                        OP_LC: begin
                            r_acc <= 64'($signed(r_tos[r_bsel*8 +: 8]));
                        end
                        OP_SI: begin
                            r_we <= 1'b1; r_waddr <= tos_b[BW-1:3]; r_wdata <= r_acc;
                        end
                        OP_SC: begin
                            r_we <= 1'b1; r_waddr <= r_raddr;
                            r_wdata <= sc_word;
                            r_acc <= 64'($signed(r_acc[7:0]));
                        end
                        OP_PSH: begin
                            r_we <= 1'b1; r_waddr <= r_sp - AW'(1);
                            r_wdata <= r_acc; r_sp <= r_sp - AW'(1);
                        end
                        OP_OR:  r_acc <= r_tos | r_acc;
                        OP_XOR: r_acc <= r_tos ^ r_acc;
                        OP_AND: r_acc <= r_tos & r_acc;
                        OP_EQ:  r_acc <= 64'(r_tos == r_acc);
                        OP_NE:  r_acc <= 64'(r_tos != r_acc);
                        OP_LT:  r_acc <= 64'(cmp_lt_pa);
                        OP_GT:  r_acc <= 64'(cmp_lt_ap);
                        OP_LE:  r_acc <= 64'(!cmp_lt_ap);
                        OP_GE:  r_acc <= 64'(!cmp_lt_pa);
                        OP_SHL: r_acc <= shl_v;
                        OP_SHR: r_acc <= shr_v;
                        OP_ADD: r_acc <= r_tos + r_acc;
                        OP_SUB: r_acc <= r_tos - r_acc;
                        OP_MUL: r_mstep <= 2'd0;
                        OP_DIV, OP_MOD: begin
                            r_xn <= r_tos[63]; r_yn <= r_acc[63];
                            r_dvd <= r_tos[63] ? -r_tos : r_tos;
                            r_dvs <= r_acc[63] ? -r_acc : r_acc;
                            r_rem <= '0; r_quo <= '0; r_cnt <= '0;
                        end
                        OP_EXIT: begin
                            r_exit <= r_tos; r_halt <= ST_EXIT; r_pc <= r_pc;
                        end
                        default: begin
                            r_halt <= ST_BAD; r_pc <= r_pc;
                        end
                    endcase
                end
                S_MUL: begin
                    // lo*lo, then cross terms added into the upper half
                    r_mstep <= r_mstep + 2'd1;
                    case (r_mstep)
                        2'd0: r_mlo <= mprod;
                        2'd1: r_mlo[63:32] <= r_mlo[63:32] + mprod[31:0];
                        2'd2: r_mlo[63:32] <= r_mlo[63:32] + mprod[31:0];
                        default: r_acc <= r_mlo;
                    endcase
                end
                S_DIV: if (r_cnt != 7'd64) begin
                    r_cnt <= r_cnt + 7'd1;
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    if (!dsub[64]) begin
                        r_rem <= dsub[63:0]; r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_dvd[63]}; r_quo <= {r_quo[62:0], 1'b0};
                    end
                end
                S_DIVFIX: begin
                    if (r_cmd == OP_DIV)
                        r_acc <= (r_dvs == 0) ? '1 : ((r_xn != r_yn) ? -r_quo : r_quo);
                    else
                        r_acc <= (r_dvs == 0) ? r_dvd0
                               : (r_xn ? -r_rem : r_rem);
                end
                S_START: begin
                    // push argc, zero argv, return pc
                    r_mstep <= r_mstep + 2'd1;
                    r_we <= 1'b1;
                    r_waddr <= AW'(MEM_WORDS - 1) - AW'(r_mstep);
                    case (r_mstep)
                        2'd0: r_wdata <= 64'(r_argc);
                        2'd1: r_wdata <= '0;
                        default: r_wdata <= 64'(r_ret);
                    endcase
                    if (r_mstep == 2'd2) begin
                        r_sp <= AW'(MEM_WORDS - 3); r_fp <= '0;
                        r_pc <= TW'(r_entry); r_acc <= '0; r_halt <= ST_RUN;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) r_dvd0 <= r_tos;
    end
endmodule
`default_nettype wire
